@@ hw/rtl/srjc_pkg.sv @@
// srjc_pkg: shared types, codes and constants of the servo remote/joystick controller
// no dependencies; imported by srjc_front, srjc_back and the top level

package srjc_pkg;

  // field widths
  localparam int unsigned ANGLE_W    = 8;
  localparam int unsigned SPEED_W    = 3;
  localparam int unsigned ENTRY_W    = 10;
  localparam int unsigned JOY_W      = 10;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DEB_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DELTA_W    = 6;

  // default depth of the command queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;

  // angle, entry and speed limits
  localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET = 8'd90;
  localparam logic [ENTRY_W-1:0] ENTRY_MAX   = 10'd999;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 3'd2;

  // configuration reset values
  localparam logic [JOY_W-1:0]   DEADZONE_RESET = 10'd50;
  localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 16'd300;
  localparam logic [JOY_W-1:0]   CENTER_RESET   = 10'd512;
  localparam logic [SPEED_W-1:0] SPD_MIN_RESET  = 3'd1;
  localparam logic [SPEED_W-1:0] SPD_MAX_RESET  = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX = 3'd4;

  // event kinds
  localparam logic [1:0] FUNC_IR    = 2'd0;
  localparam logic [1:0] FUNC_PRESS = 2'd1;
  localparam logic [1:0] FUNC_STICK = 2'd2;

  // remote codes
  localparam logic [CODE_W-1:0] CODE_NONE   = 32'h0000_0000;
  localparam logic [CODE_W-1:0] CODE_REPEAT = 32'hFFFF_FFFF;
  localparam logic [CODE_W-1:0] CODE_NEAR   = 32'hF609_FF00;
  localparam logic [CODE_W-1:0] CODE_FAR    = 32'hF807_FF00;
  localparam logic [CODE_W-1:0] CODE_TEST   = 32'hBB44_FF00;
  localparam logic [CODE_W-1:0] CODE_FASTER = 32'hBF40_FF00;
  localparam logic [CODE_W-1:0] CODE_SLOWER = 32'hE619_FF00;
  localparam logic [CODE_W-1:0] CODE_COMMIT = 32'hEA15_FF00;

  localparam logic [CODE_W-1:0] DIGIT_CODES [10] = '{
    32'hE916_FF00, 32'hF30C_FF00, 32'hE718_FF00, 32'hA15E_FF00, 32'hF708_FF00,
    32'hE31C_FF00, 32'hA55A_FF00, 32'hBD42_FF00, 32'hAD52_FF00, 32'hB54A_FF00
  };

  // commands passed from front to back
  localparam logic [2:0] OP_NOP       = 3'd0;
  localparam logic [2:0] OP_SET_ANGLE = 3'd1;
  localparam logic [2:0] OP_DIGIT     = 3'd2;
  localparam logic [2:0] OP_COMMIT    = 3'd3;
  localparam logic [2:0] OP_LOCK_ON   = 3'd4;
  localparam logic [2:0] OP_LOCK_OFF  = 3'd5;
  localparam logic [2:0] OP_MOVE      = 3'd6;

  // joystick step: floor(p / 4000) as (x * 67109) >> 28, exact for x < 2^17
  localparam int unsigned PROD_W    = 17;
  localparam int unsigned QUOT_W    = 5;
  localparam int unsigned DIV_SHIFT = 28;
  localparam logic [PROD_W-1:0] DIV_RECIP = 17'd67109;
  localparam logic [PROD_W-1:0] DIV_ROUND = 17'd3999;
  localparam logic [6:0]        STEP_MUL  = 7'd11;

  typedef struct packed {
    logic [1:0]        func;
    logic [CODE_W-1:0] ir_code;
    logic [TIME_W-1:0] now_ms;
    logic [JOY_W-1:0]  joystick;
    logic [ANGLE_W-1:0] random_angle;
  } srjc_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [SPEED_W-1:0] speed_halves;
    logic               is_locked;
    logic [ENTRY_W-1:0] entry_value;
    logic               entry_present;
  } srjc_out_t;

  typedef struct packed {
    logic [JOY_W-1:0]   deadzone;
    logic [DEB_W-1:0]   debounce_ms;
    logic [JOY_W-1:0]   joystick_center;
    logic [SPEED_W-1:0] speed_min_halves;
    logic [SPEED_W-1:0] speed_max_halves;
  } srjc_cfg_t;

  typedef struct packed {
    logic [2:0]                op;
    logic [ANGLE_W-1:0]        arg;
    logic signed [DELTA_W-1:0] delta;
    logic [SPEED_W-1:0]        speed;
    logic                      lock;
  } srjc_cmd_t;

  // digit key lookup: {hit, digit}
  function automatic logic [4:0] digit_decode(input logic [CODE_W-1:0] code);
    logic [4:0] res;
    res = '0;
    for (int i = 0; i < 10; i++) begin
      if (code == DIGIT_CODES[i]) begin
        res = {1'b1, 4'(i)};
      end
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/srjc_fifo.sv @@
// srjc_fifo: small register queue carrying commands from front to back
// generic width and depth; no package dependency

module srjc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       nempty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // pointer advance with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(wr_en) - CNT_W'(rd_en);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign nempty  = (count_r != '0);
  assign count   = count_r;

endmodule

@@ hw/rtl/srjc_front.sv @@
// srjc_front: accepts events, owns lock, debounce and speed state, and turns
// each event into a back-end command; joystick step computed over two stages
// depends on srjc_pkg

module srjc_front #(
  parameter int unsigned FIFO_DEPTH = srjc_pkg::FIFO_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  srjc_pkg::srjc_in_t              in_data,
  input  srjc_pkg::srjc_cfg_t             cfg,
  input  logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_count,
  output logic                            cmd_valid,
  output srjc_pkg::srjc_cmd_t             cmd
);

  import srjc_pkg::*;

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH+1);

  logic                accept;
  logic [CNT_W:0]      used;

  // front state
  logic                lock_r, lock_nxt;
  logic [TIME_W-1:0]   last_r, last_nxt;
  logic [SPEED_W-1:0]  speed_r, speed_nxt;

  // decode results
  logic                ir_ignore;
  logic [4:0]          digit_hit;
  logic [3:0]          spd_up, spd_dn;
  logic [SPEED_W-1:0]  spd_up_b, spd_dn_b;
  logic [TIME_W-1:0]   elapsed;
  logic                press_ok;
  logic [JOY_W:0]      c_raw, c_mag;
  logic                dead;
  logic [ANGLE_W-1:0]  test_angle;

  // command fields before stage one
  logic [2:0]          op;
  logic [ANGLE_W-1:0]  arg;
  logic [JOY_W-1:0]    mag;
  logic                neg;

  // stage one
  logic                s1_v_r;
  logic [2:0]          s1_op_r;
  logic [ANGLE_W-1:0]  s1_arg_r;
  logic [SPEED_W-1:0]  s1_speed_r;
  logic                s1_lock_r;
  logic [JOY_W-1:0]    s1_mag_r;
  logic                s1_neg_r;
  logic [6:0]          s1_step;

  // stage two
  logic                s2_v_r;
  logic [2:0]          s2_op_r;
  logic [ANGLE_W-1:0]  s2_arg_r;
  logic [SPEED_W-1:0]  s2_speed_r;
  logic                s2_lock_r;
  logic [PROD_W-1:0]   s2_prod_r;
  logic                s2_neg_r;

  // divide by 4000
  logic [PROD_W-1:0]   div_x;
  logic [2*PROD_W-1:0] div_prod;
  logic [DELTA_W-1:0]  quot;
  logic [DELTA_W-1:0]  delta_u;

  // space check over the queue and the beats still in the pipeline
  assign used     = {1'b0, fifo_count} + (CNT_W+1)'(s1_v_r) + (CNT_W+1)'(s2_v_r);
  assign in_stall = (used >= (CNT_W+1)'(FIFO_DEPTH));
  assign accept   = in_valid & ~in_stall;

  // remote code classification
  assign ir_ignore = (in_data.ir_code == CODE_NONE) || (in_data.ir_code == CODE_REPEAT) ||
                     lock_r;
  assign digit_hit = digit_decode(in_data.ir_code);
  assign test_angle = (in_data.random_angle > ANGLE_MAX) ? ANGLE_MAX : in_data.random_angle;

  // speed step, lower bound checked first
  assign spd_up   = {1'b0, speed_r} + 4'd1;
  assign spd_dn   = {1'b0, speed_r} - 4'd1;
  assign spd_up_b = (spd_up < {1'b0, cfg.speed_min_halves}) ? cfg.speed_min_halves :
                    (spd_up > {1'b0, cfg.speed_max_halves}) ? cfg.speed_max_halves :
                    spd_up[SPEED_W-1:0];
  assign spd_dn_b = ((speed_r == '0) || (spd_dn < {1'b0, cfg.speed_min_halves})) ?
                    cfg.speed_min_halves :
                    (spd_dn > {1'b0, cfg.speed_max_halves}) ? cfg.speed_max_halves :
                    spd_dn[SPEED_W-1:0];

  // lock button debounce, wrapping time difference
  assign elapsed  = in_data.now_ms - last_r;
  assign press_ok = elapsed > TIME_W'(cfg.debounce_ms);

  // joystick centring and deadzone
  assign c_raw = {1'b0, in_data.joystick} - {1'b0, cfg.joystick_center};
  assign c_mag = c_raw[JOY_W] ? ((JOY_W+1)'(0) - c_raw) : c_raw;
  assign dead  = c_mag[JOY_W-1:0] < cfg.deadzone;

  // event handling and next front state
  always_comb begin
    lock_nxt  = lock_r;
    last_nxt  = last_r;
    speed_nxt = speed_r;
    op        = OP_NOP;
    arg       = '0;
    mag       = '0;
    neg       = 1'b0;
    if (accept) begin
      case (in_data.func)
        FUNC_IR: begin
          if (!ir_ignore) begin
            if (in_data.ir_code == CODE_NEAR) begin
              op = OP_SET_ANGLE;
            end else if (in_data.ir_code == CODE_FAR) begin
              op  = OP_SET_ANGLE;
              arg = ANGLE_MAX;
            end else if (in_data.ir_code == CODE_TEST) begin
              op  = OP_SET_ANGLE;
              arg = test_angle;
            end else if (in_data.ir_code == CODE_FASTER) begin
              speed_nxt = spd_up_b;
            end else if (in_data.ir_code == CODE_SLOWER) begin
              speed_nxt = spd_dn_b;
            end else if (digit_hit[4]) begin
              op  = OP_DIGIT;
              arg = {4'd0, digit_hit[3:0]};
            end else if (in_data.ir_code == CODE_COMMIT) begin
              op = OP_COMMIT;
            end
          end
        end
        FUNC_PRESS: begin
          if (press_ok) begin
            last_nxt = in_data.now_ms;
            lock_nxt = ~lock_r;
            op       = lock_r ? OP_LOCK_OFF : OP_LOCK_ON;
          end
        end
        FUNC_STICK: begin
          if (!lock_r) begin
            op  = OP_MOVE;
            mag = dead ? '0 : c_mag[JOY_W-1:0];
            neg = c_raw[JOY_W] & ~dead;
          end
        end
        default: begin
          op = OP_NOP;
        end
      endcase
    end
  end

  // front state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r  <= 1'b0;
      last_r  <= '0;
      speed_r <= SPEED_RESET;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      lock_r  <= lock_nxt;
      last_r  <= last_nxt;
      speed_r <= speed_nxt;
      s1_v_r  <= accept;
      s2_v_r  <= s1_v_r;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    s1_op_r    <= op;
    s1_arg_r   <= arg;
    s1_speed_r <= speed_nxt;
    s1_lock_r  <= lock_nxt;
    s1_mag_r   <= mag;
    s1_neg_r   <= neg;
  end

  // stage two: magnitude times speed times eleven
  assign s1_step = {4'd0, s1_speed_r} * STEP_MUL;

  always_ff @(posedge clk) begin
    s2_op_r    <= s1_op_r;
    s2_arg_r   <= s1_arg_r;
    s2_speed_r <= s1_speed_r;
    s2_lock_r  <= s1_lock_r;
    s2_prod_r  <= PROD_W'(s1_mag_r) * PROD_W'(s1_step);
    s2_neg_r   <= s1_neg_r;
  end

  // floor division by 4000, rounding away from zero when negative
  assign div_x    = s2_neg_r ? (s2_prod_r + DIV_ROUND) : s2_prod_r;
  assign div_prod = (2*PROD_W)'(div_x) * (2*PROD_W)'(DIV_RECIP);
  assign quot     = {1'b0, div_prod[DIV_SHIFT +: QUOT_W]};
  assign delta_u  = s2_neg_r ? (DELTA_W'(0) - quot) : quot;

  assign cmd_valid = s2_v_r;
  always_comb begin
    cmd.op    = s2_op_r;
    cmd.arg   = s2_arg_r;
    cmd.delta = $signed(delta_u);
    cmd.speed = s2_speed_r;
    cmd.lock  = s2_lock_r;
  end

endmodule

@@ hw/rtl/srjc_back.sv @@
// srjc_back: executes commands on the servo angle and the typed entry and
// holds the result register; depends on srjc_pkg

module srjc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  srjc_pkg::srjc_cmd_t  cmd,
  output logic                 cmd_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output srjc_pkg::srjc_out_t  out_data
);

  import srjc_pkg::*;

  logic [ANGLE_W-1:0]  angle_r, angle_nxt;
  logic [ENTRY_W-1:0]  typed_r, typed_nxt;
  logic                present_r, present_nxt;
  logic                out_valid_r, out_valid_nxt;
  srjc_out_t           out_data_r;

  logic signed [9:0]   move_sum;
  logic [13:0]         digit_sum;

  // take a command when the result register is free or being drained
  assign cmd_pop       = cmd_valid & (~out_valid_r | ~out_stall);
  assign out_valid_nxt = cmd_pop | (out_valid_r & out_stall);

  assign move_sum  = $signed({2'b00, angle_r}) + $signed({{4{cmd.delta[DELTA_W-1]}}, cmd.delta});
  assign digit_sum = 14'(typed_r) * 14'd10 + 14'(cmd.arg[3:0]);

  // command execution
  always_comb begin
    angle_nxt   = angle_r;
    typed_nxt   = typed_r;
    present_nxt = present_r;
    if (cmd_pop) begin
      case (cmd.op)
        OP_SET_ANGLE: begin
          angle_nxt = cmd.arg;
        end
        OP_DIGIT: begin
          typed_nxt   = (digit_sum > 14'(ENTRY_MAX)) ? ENTRY_MAX : digit_sum[ENTRY_W-1:0];
          present_nxt = 1'b1;
        end
        OP_COMMIT: begin
          if (present_r) begin
            angle_nxt   = (typed_r > ENTRY_W'(ANGLE_MAX)) ? ANGLE_MAX : typed_r[ANGLE_W-1:0];
            typed_nxt   = '0;
            present_nxt = 1'b0;
          end
        end
        OP_LOCK_ON: begin
          typed_nxt   = ENTRY_W'(angle_r);
          present_nxt = 1'b1;
        end
        OP_LOCK_OFF: begin
          typed_nxt   = '0;
          present_nxt = 1'b0;
        end
        OP_MOVE: begin
          if (move_sum < 0) begin
            angle_nxt = '0;
          end else if (move_sum > $signed(10'(ANGLE_MAX))) begin
            angle_nxt = ANGLE_MAX;
          end else begin
            angle_nxt = move_sum[ANGLE_W-1:0];
          end
        end
        default: begin
          angle_nxt = angle_r;
        end
      endcase
    end
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r     <= ANGLE_RESET;
      typed_r     <= '0;
      present_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      angle_r     <= angle_nxt;
      typed_r     <= typed_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_data_r.angle         <= angle_nxt;
      out_data_r.speed_halves  <= cmd.speed;
      out_data_r.is_locked     <= cmd.lock;
      out_data_r.entry_value   <= typed_nxt;
      out_data_r.entry_present <= present_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/servo_remote_joystick_control_top.sv @@
// Servo remote/joystick controller, top level.
// Input channel (in_valid/in_stall/in_data): one event per beat, either a
// remote code, a lock-button press with its millisecond timestamp, or a
// joystick sample. Every accepted beat yields exactly one result beat on the
// output channel (out_valid/out_stall/out_data) with the angle, speed, lock
// and typed entry after that event, in order.
// Path of an event: the edge that takes it loads the first front stage;
// the joystick multiply stage, the command queue and the back end's result
// register follow.
// Throughput: one event per cycle while in_stall stays low, set by the state
// update in the front (lock, speed) and in the back (angle, entry).
// A four-entry command queue sits between front and back; in_stall rises when
// the queue plus the beats in the front pipeline would fill it, so a stalled
// receiver backs up into the input channel without losing beats.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset (rst_n low, synchronous): angle 90, speed 2, unlocked, entry empty,
// last press time 0, all configuration registers at their defaults.
// depends on srjc_pkg, srjc_front, srjc_fifo, srjc_back

module servo_remote_joystick_control_top #(
  parameter int unsigned FIFO_DEPTH = srjc_pkg::FIFO_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  srjc_pkg::srjc_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output srjc_pkg::srjc_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srjc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srjc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import srjc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(FIFO_DEPTH+1);
  localparam int unsigned CMD_W  = $bits(srjc_cmd_t);

  srjc_cfg_t            cfg_r, cfg_nxt;
  logic                 cfg_wr;

  logic                 cmd_wr;
  srjc_cmd_t            cmd_in;
  logic [CMD_W-1:0]     cmd_rd_bits;
  srjc_cmd_t            cmd_out;
  logic                 cmd_nempty;
  logic                 cmd_pop;
  logic [CNT_W-1:0]     fifo_count;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_DEADZONE:  cfg_nxt.deadzone         = cfg_data[JOY_W-1:0];
        CFG_DEBOUNCE:  cfg_nxt.debounce_ms      = cfg_data[DEB_W-1:0];
        CFG_CENTER:    cfg_nxt.joystick_center  = cfg_data[JOY_W-1:0];
        CFG_SPEED_MIN: cfg_nxt.speed_min_halves = cfg_data[SPEED_W-1:0];
        CFG_SPEED_MAX: cfg_nxt.speed_max_halves = cfg_data[SPEED_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone         <= DEADZONE_RESET;
      cfg_r.debounce_ms      <= DEBOUNCE_RESET;
      cfg_r.joystick_center  <= CENTER_RESET;
      cfg_r.speed_min_halves <= SPD_MIN_RESET;
      cfg_r.speed_max_halves <= SPD_MAX_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accept and classify
  srjc_front #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .fifo_count (fifo_count),
    .cmd_valid  (cmd_wr),
    .cmd        (cmd_in)
  );

  // command queue
  srjc_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd_bits),
    .nempty  (cmd_nempty),
    .count   (fifo_count)
  );

  assign cmd_out = cmd_rd_bits;

  // back: execute and present results
  srjc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_nempty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ verif/tb_servo_remote_joystick_control_top.sv @@
// testbench for servo_remote_joystick_control_top: remote keys, lock button and joystick events
// checked beat by beat against an in-bench model of angle, speed, lock and typed entry
// depends on srjc_pkg and the rtl of the block; self-contained otherwise

module tb_servo_remote_joystick_control_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srjc_pkg::*;

  localparam int RESET_CYCLES     = 11;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int HOLD_CYCLES      = 120;
  localparam int TAIL_CYCLES      = 8;
  localparam int RANDOM_PER_PHASE = 285;
  localparam int NUM_PHASES       = 6;

  // event kind with no effect
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // joystick step is floor(c * speed * 11 / 4000)
  localparam int STEP_NUM    = 11;
  localparam int STEP_DEN    = 4000;
  localparam int ANGLE_LIMIT = 180;
  localparam int ENTRY_LIMIT = 999;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  srjc_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  srjc_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // model state of the servo controller
  logic [ANGLE_W-1:0] srv_angle      = 8'd90;
  logic [SPEED_W-1:0] srv_speed      = 3'd2;
  logic               srv_locked     = 1'b0;
  logic [ENTRY_W-1:0] srv_entry      = '0;
  logic               srv_entry_held = 1'b0;
  logic [TIME_W-1:0]  srv_last_press = '0;

  // shadow of the configuration registers
  logic [JOY_W-1:0]   dz_reg       = 10'd50;
  logic [DEB_W-1:0]   debounce_reg = 16'd300;
  logic [JOY_W-1:0]   center_reg   = 10'd512;
  logic [SPEED_W-1:0] spd_min_reg  = 3'd1;
  logic [SPEED_W-1:0] spd_max_reg  = 3'd7;

  srjc_out_t         results_due[$];
  int                err_count     = 0;
  int                cycle_count   = 0;
  bit                tx_idle_on    = 1'b1;
  bit                rx_idle_on    = 1'b1;
  bit                long_hold_req = 1'b0;
  logic [TIME_W-1:0] press_clock   = '0;

  servo_remote_joystick_control_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // gap length: mostly short, now and then long
  function automatic int pick_gap(input int min_len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return min_len + $urandom_range(0, 2);
    if (r < 94) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [SPEED_W-1:0] clamp_speed(input int s);
    if (s < int'(spd_min_reg)) return spd_min_reg;
    if (s > int'(spd_max_reg)) return spd_max_reg;
    return s[SPEED_W-1:0];
  endfunction

  // advance the servo model by one event and report the state after it
  function automatic srjc_out_t servo_after(input srjc_in_t ev);
    srjc_out_t         r;
    int                c, p, d, a, v, dig, k;
    logic [TIME_W-1:0] elapsed;
    case (ev.func)
      FUNC_IR: begin
        dig = -1;
        for (k = 0; k < 10; k++) begin
          if (ev.ir_code == DIGIT_CODES[k]) dig = k;
        end
        // zero, repeat and any key while locked are discarded
        if (!(ev.ir_code == CODE_NONE || ev.ir_code == CODE_REPEAT || srv_locked)) begin
          if (ev.ir_code == CODE_NEAR) begin
            srv_angle = '0;
          end else if (ev.ir_code == CODE_FAR) begin
            srv_angle = ANGLE_LIMIT[ANGLE_W-1:0];
          end else if (ev.ir_code == CODE_TEST) begin
            srv_angle = (int'(ev.random_angle) > ANGLE_LIMIT) ?
                        ANGLE_LIMIT[ANGLE_W-1:0] : ev.random_angle;
          end else if (ev.ir_code == CODE_FASTER) begin
            srv_speed = clamp_speed(int'(srv_speed) + 1);
          end else if (ev.ir_code == CODE_SLOWER) begin
            srv_speed = clamp_speed(int'(srv_speed) - 1);
          end else if (dig >= 0) begin
            // typed entry saturates instead of wrapping
            v = int'(srv_entry) * 10 + dig;
            if (v > ENTRY_LIMIT) v = ENTRY_LIMIT;
            srv_entry = v[ENTRY_W-1:0];
            srv_entry_held = 1'b1;
          end else if (ev.ir_code == CODE_COMMIT && srv_entry_held) begin
            v = int'(srv_entry);
            if (v > ANGLE_LIMIT) v = ANGLE_LIMIT;
            srv_angle = v[ANGLE_W-1:0];
            srv_entry = '0;
            srv_entry_held = 1'b0;
          end
        end
      end
      FUNC_PRESS: begin
        // elapsed time wraps with the millisecond counter
        elapsed = ev.now_ms - srv_last_press;
        if (elapsed > debounce_reg) begin
          srv_last_press = ev.now_ms;
          srv_locked = ~srv_locked;
          if (srv_locked) begin
            srv_entry = {{(ENTRY_W-ANGLE_W){1'b0}}, srv_angle};
            srv_entry_held = 1'b1;
          end else begin
            srv_entry = '0;
            srv_entry_held = 1'b0;
          end
        end
      end
      FUNC_STICK: begin
        if (!srv_locked) begin
          c = int'(ev.joystick) - int'(center_reg);
          if ((c < 0 ? -c : c) < int'(dz_reg)) c = 0;
          p = c * int'(srv_speed) * STEP_NUM;
          // floor division, also for negative steps
          d = (p >= 0) ? p / STEP_DEN : -((-p + STEP_DEN - 1) / STEP_DEN);
          a = int'(srv_angle) + d;
          if (a < 0) a = 0;
          if (a > ANGLE_LIMIT) a = ANGLE_LIMIT;
          srv_angle = a[ANGLE_W-1:0];
        end
      end
      default: ;
    endcase
    r.angle         = srv_angle;
    r.speed_halves  = srv_speed;
    r.is_locked     = srv_locked;
    r.entry_value   = srv_entry;
    r.entry_present = srv_entry_held;
    return r;
  endfunction

  function automatic srjc_in_t make_event(input logic [1:0] func,
                                          input logic [CODE_W-1:0] code,
                                          input logic [TIME_W-1:0] now,
                                          input logic [JOY_W-1:0] joy,
                                          input logic [ANGLE_W-1:0] ang);
    srjc_in_t ev;
    ev.func         = func;
    ev.ir_code      = code;
    ev.now_ms       = now;
    ev.joystick     = joy;
    ev.random_angle = ang;
    return ev;
  endfunction

  // random event: mostly meaningful keys, presses around the debounce time
  function automatic srjc_in_t random_event();
    srjc_in_t ev;
    int       r, j;
    ev.ir_code      = $urandom();
    ev.now_ms       = $urandom();
    ev.joystick     = JOY_W'($urandom_range(0, 1023));
    ev.random_angle = ($urandom_range(0, 9) == 0) ? ANGLE_W'($urandom_range(0, 255)) :
                      ANGLE_W'($urandom_range(0, 179));
    r = $urandom_range(0, 99);
    if (r < 52) begin
      ev.func = FUNC_IR;
      r = $urandom_range(0, 99);
      if (r < 35)      ev.ir_code = DIGIT_CODES[$urandom_range(0, 9)];
      else if (r < 45) ev.ir_code = CODE_COMMIT;
      else if (r < 55) ev.ir_code = CODE_FASTER;
      else if (r < 65) ev.ir_code = CODE_SLOWER;
      else if (r < 72) ev.ir_code = CODE_NEAR;
      else if (r < 79) ev.ir_code = CODE_FAR;
      else if (r < 88) ev.ir_code = CODE_TEST;
      else if (r < 92) ev.ir_code = CODE_NONE;
      else if (r < 95) ev.ir_code = CODE_REPEAT;
    end else if (r < 62) begin
      ev.func = FUNC_PRESS;
      if ($urandom_range(0, 9) != 0) begin
        press_clock = press_clock + $urandom_range(0, 2 * int'(debounce_reg) + 2);
        ev.now_ms = press_clock;
      end else begin
        press_clock = ev.now_ms;
      end
    end else if (r < 97) begin
      ev.func = FUNC_STICK;
      if ($urandom_range(0, 3) == 0) begin
        // hover around the deadzone edges
        j = int'(center_reg) + int'($urandom_range(0, 2 * int'(dz_reg) + 8))
            - (int'(dz_reg) + 4);
        if (j < 0) j = 0;
        if (j > 1023) j = 1023;
        ev.joystick = j[JOY_W-1:0];
      end
    end else begin
      ev.func = FUNC_NONE;
    end
    return ev;
  endfunction

  // send one event beat and queue the state expected after it
  task automatic send_event(input srjc_in_t ev);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 1) == 1) ? pick_gap(1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    results_due.push_back(servo_after(ev));
  endtask

  // sender stops until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEADZONE:  dz_reg       = val[JOY_W-1:0];
      CFG_DEBOUNCE:  debounce_reg = val[DEB_W-1:0];
      CFG_CENTER:    center_reg   = val[JOY_W-1:0];
      CFG_SPEED_MIN: spd_min_reg  = val[SPEED_W-1:0];
      CFG_SPEED_MAX: spd_max_reg  = val[SPEED_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned dz, input int unsigned deb,
                            input int unsigned ctr, input int unsigned mn,
                            input int unsigned mx);
    write_reg(CFG_DEADZONE, dz);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_CENTER, ctr);
    write_reg(CFG_SPEED_MIN, mn);
    write_reg(CFG_SPEED_MAX, mx);
    cfg_valid <= 1'b0;
  endtask

  // reset state report and discarded codes
  task automatic test_reset_report();
    send_event(make_event(FUNC_NONE, $urandom(), $urandom(), 10'h3FF, 8'hFF));
    send_event(make_event(FUNC_IR, CODE_NONE, '0, '0, 8'd10));
    send_event(make_event(FUNC_IR, CODE_REPEAT, '1, '1, 8'd10));
  endtask

  // each command key and the nine digit key, saturation of the test key and of the entry
  task automatic test_remote_keys();
    int k;
    send_event(make_event(FUNC_IR, CODE_NEAR, '0, '0, 8'd33));
    send_event(make_event(FUNC_IR, CODE_FAR, '0, '0, 8'd33));
    send_event(make_event(FUNC_IR, CODE_TEST, '0, '0, 8'd255));
    send_event(make_event(FUNC_IR, CODE_SLOWER, '0, '0, 8'd0));
    send_event(make_event(FUNC_IR, CODE_SLOWER, '0, '0, 8'd0));
    send_event(make_event(FUNC_IR, CODE_FASTER, '0, '0, 8'd0));
    // commit with nothing typed does nothing
    send_event(make_event(FUNC_IR, CODE_COMMIT, '0, '0, 8'd0));
    for (k = 0; k < 4; k++) begin
      send_event(make_event(FUNC_IR, DIGIT_CODES[9], '0, '0, 8'd0));
    end
    send_event(make_event(FUNC_IR, CODE_COMMIT, '0, '0, 8'd0));
  endtask

  // lock toggles, debounce edge, lockout of keys and stick, timestamp wrap
  task automatic test_lock_button();
    send_event(make_event(FUNC_PRESS, '0, 32'd100, '0, '0));
    send_event(make_event(FUNC_PRESS, '0, 32'd301, '0, '0));
    send_event(make_event(FUNC_IR, CODE_FAR, '0, '0, '0));
    send_event(make_event(FUNC_STICK, '0, '0, 10'd1023, '0));
    send_event(make_event(FUNC_PRESS, '0, 32'd601, '0, '0));
    send_event(make_event(FUNC_PRESS, '0, 32'hFFFF_FF00, '0, '0));
    send_event(make_event(FUNC_PRESS, '0, 32'h0000_0010, '0, '0));
    press_clock = 32'h0000_0010;
  endtask

  // stick extremes and both sides of the deadzone
  task automatic test_joystick();
    send_event(make_event(FUNC_STICK, '0, '0, 10'd0, '0));
    send_event(make_event(FUNC_STICK, '0, '0, 10'd1023, '0));
    send_event(make_event(FUNC_STICK, '0, '0, 10'd561, '0));
    send_event(make_event(FUNC_STICK, '0, '0, 10'd462, '0));
  endtask

  // long receiver hold so the block fills and stalls its input
  task automatic test_backpressure();
    int k;
    drain_results();
    tx_idle_on = 1'b0;
    long_hold_req = 1'b1;
    for (k = 0; k < 24; k++) send_event(random_event());
    drain_results();
    tx_idle_on = 1'b1;
    for (k = 0; k < 10; k++) send_event(random_event());
  endtask

  // random traffic under a series of register settings
  task automatic test_config_phases();
    int          ph, counted;
    int unsigned mn;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: set_config(50, 300, 512, 1, 7);
        1: set_config(0, 0, 0, 1, 7);
        2: set_config(512, 65535, 1023, 7, 7);
        3: set_config($urandom_range(0, 512), $urandom_range(0, 1000),
                      $urandom_range(0, 1023), 4, 2);
        4: begin
          mn = $urandom_range(1, 7);
          set_config($urandom_range(0, 512), $urandom_range(0, 65535),
                     $urandom_range(0, 1023), mn, $urandom_range(mn, 7));
        end
        default: set_config(0, 0, 1023, 1, 1);
      endcase
      tx_idle_on = (ph != 2 && ph != 3);
      rx_idle_on = (ph != 1 && ph != 3);
      for (counted = 0; counted < RANDOM_PER_PHASE; counted++) begin
        send_event(random_event());
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin : receiver
    int n;
    wait (rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        n = pick_gap(1);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      err_count++;
    end
  endtask

  // compare each result beat with the oldest expected state
  always @(posedge clk) begin
    srjc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        err_count++;
      end else begin
        want = results_due.pop_front();
        check_field("angle", want.angle, out_data.angle);
        check_field("speed_halves", want.speed_halves, out_data.speed_halves);
        check_field("is_locked", want.is_locked, out_data.is_locked);
        check_field("entry_value", want.entry_value, out_data.entry_value);
        check_field("entry_present", want.entry_present, out_data.entry_present);
      end
    end
  end

  initial begin : run
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_report();
    test_remote_keys();
    test_lock_button();
    test_joystick();
    test_backpressure();
    test_config_phases();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
